### src/three_queue_work_stealing_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-queue work-stealing scheduler
// Clocked concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef THREE_QUEUE_WORK_STEALING_SCHEDULER_DEFINES_SVH
`define THREE_QUEUE_WORK_STEALING_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define TQWS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("tqws assertion failed");

// Check that a condition never holds outside reset
`define TQWS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("tqws forbidden condition seen");

`else

`define TQWS_ASSERT(lbl, clk, rst_n, prop)
`define TQWS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/tqws_pkg.sv
// ----------------------------------------------------------------------------
// tqws_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tqws_pkg;

	// Default sizing
	localparam int QUEUE_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF   = 4;

	// Fixed port widths
	localparam int NUM_QUEUES = 3;
	localparam int QSEL_W     = 2;
	localparam int TIME_W     = 4;
	localparam int CNT_W      = 4;

	// Queue codes
	localparam logic [QSEL_W-1:0] Q_A    = 2'd0;
	localparam logic [QSEL_W-1:0] Q_B    = 2'd1;
	localparam logic [QSEL_W-1:0] Q_C    = 2'd2;
	localparam logic [QSEL_W-1:0] Q_NONE = 2'd3;

	// Steal source codes
	localparam logic [QSEL_W-1:0] STEAL_NONE = 2'd0;
	localparam logic [QSEL_W-1:0] STEAL_A    = 2'd1;
	localparam logic [QSEL_W-1:0] STEAL_B    = 2'd2;
	localparam logic [QSEL_W-1:0] STEAL_C    = 2'd3;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_LOAD,
		ST_DONE
	} tqws_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic              accept;
		logic              eval;
		logic              load;
		logic              out_load;
		logic [QSEL_W-1:0] worker;
	} tqws_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_load;
	} tqws_stat_t;

	// Map a victim queue to its steal source code
	function automatic logic [QSEL_W-1:0] steal_code(input logic [QSEL_W-1:0] q);
		logic [QSEL_W-1:0] code;
		case (q)
			Q_A:     code = STEAL_A;
			Q_B:     code = STEAL_B;
			Q_C:     code = STEAL_C;
			default: code = STEAL_NONE;
		endcase
		return code;
	endfunction

endpackage

### src/tqws_ctrl.sv
// ----------------------------------------------------------------------------
// tqws_ctrl
// Tick sequencer: accept, three worker phases, result hand-off.
// ----------------------------------------------------------------------------
`include "three_queue_work_stealing_scheduler_defines.svh"

module tqws_ctrl
	import tqws_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  tqws_stat_t stat,
	output tqws_cmd_t  cmd
);

	tqws_state_t       state_q, state_d;
	logic [QSEL_W-1:0] worker_q, worker_d;
	logic              out_valid_q, out_valid_d;

	// State, worker index and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			worker_q    <= Q_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			worker_q    <= worker_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		worker_d     = worker_q;
		cmd.accept   = 1'b0;
		cmd.eval     = 1'b0;
		cmd.load     = 1'b0;
		cmd.out_load = 1'b0;
		cmd.worker   = worker_q;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					worker_d   = Q_A;
					state_d    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.need_load) begin
					state_d = ST_LOAD;
				end else if (worker_q == Q_C) begin
					state_d = ST_DONE;
				end else begin
					worker_d = worker_q + 1'b1;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				if (worker_q == Q_C) begin
					state_d = ST_DONE;
				end else begin
					worker_d = worker_q + 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the result until the transaction completes
	always_comb begin
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	`TQWS_ASSERT(a_accept_starts_a, clk, arst_n,
		(in_valid && in_ready) |=> (state_q == ST_EVAL && worker_q == Q_A))
	`TQWS_ASSERT(a_load_after_eval, clk, arst_n,
		(state_q == ST_LOAD) |-> ($past(state_q) == ST_EVAL))
	`TQWS_ASSERT(a_done_after_c, clk, arst_n,
		(state_q == ST_DONE) |-> (worker_q == Q_C))
	`TQWS_ASSERT_NEVER(a_no_overwrite, clk, arst_n,
		cmd.out_load && out_valid_q && !out_ready)

endmodule

### src/tqws_dpath.sv
// ----------------------------------------------------------------------------
// tqws_dpath
// Deque pointers, task memory, worker timers and result registers.
// ----------------------------------------------------------------------------
module tqws_dpath
	import tqws_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tqws_cmd_t         cmd,
	output tqws_stat_t        stat,
	input  logic              has_task,
	input  logic [TIME_W-1:0] task_time,
	output logic [QSEL_W-1:0] assigned_queue,
	output logic              overflow,
	output logic [TIME_W-1:0] remaining_a,
	output logic [TIME_W-1:0] remaining_b,
	output logic [TIME_W-1:0] remaining_c,
	output logic [QSEL_W-1:0] steal_src_a,
	output logic [QSEL_W-1:0] steal_src_b,
	output logic [QSEL_W-1:0] steal_src_c,
	output logic [CNT_W-1:0]  count_a,
	output logic [CNT_W-1:0]  count_b,
	output logic [CNT_W-1:0]  count_c
);

	localparam int PW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int SW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
	localparam int DEPTH = NUM_QUEUES * QUEUE_SLOTS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

	// Circular pointer helpers
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? LAST_SLOT : p - 1'b1;
	endfunction

	function automatic logic [AW-1:0] mem_addr(input logic [QSEL_W-1:0] q,
		input logic [PW-1:0] idx);
		return AW'(AW'(q) * AW'(QUEUE_SLOTS) + AW'(idx));
	endfunction

	logic [PW-1:0]     head_q [NUM_QUEUES];
	logic [PW-1:0]     tail_q [NUM_QUEUES];
	logic [SW-1:0]     rem_q  [NUM_QUEUES];
	logic [QSEL_W-1:0] steal_q [NUM_QUEUES];
	logic [QSEL_W-1:0] assigned_q;
	logic              overflow_q;
	logic [SW-1:0]     mem [DEPTH];
	logic [SW-1:0]     rdata_q;
	logic [PW-1:0]     cnt [NUM_QUEUES];

	// Per-deque occupancy, wrapping at the slot count
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			cnt[i] = (tail_q[i] >= head_q[i]) ? tail_q[i] - head_q[i]
				: tail_q[i] + PW'(QUEUE_SLOTS) - head_q[i];
		end
	end

	// Pick the emptiest deque for an arrival
	logic [QSEL_W-1:0] sel_q;
	logic              sel_full;
	logic              wr_en;
	logic [PW-1:0]     tail_next;
	logic [AW-1:0]     waddr;

	always_comb begin
		if (cnt[0] <= cnt[1] && cnt[0] <= cnt[2]) begin
			sel_q = Q_A;
		end else if (cnt[1] <= cnt[2]) begin
			sel_q = Q_B;
		end else begin
			sel_q = Q_C;
		end
		sel_full  = (cnt[sel_q] == LAST_SLOT);
		wr_en     = cmd.accept && has_task && !sel_full;
		tail_next = ptr_inc(tail_q[sel_q]);
		waddr     = mem_addr(sel_q, tail_next);
	end

	// Decide what the current worker does
	logic [QSEL_W-1:0] w;
	logic [QSEL_W-1:0] o1, o2, victim;
	logic              busy, do_pop, do_steal, rd_en;
	logic [AW-1:0]     raddr;

	always_comb begin
		w        = cmd.worker;
		o1       = (w == Q_A) ? Q_B : Q_A;
		o2       = (w == Q_C) ? Q_B : Q_C;
		victim   = (cnt[o1] >= cnt[o2]) ? o1 : o2;
		busy     = (rem_q[w] != '0);
		do_pop   = !busy && (cnt[w] != '0);
		do_steal = !busy && (cnt[w] == '0) && (cnt[victim] != '0);
		if (do_pop) begin
			raddr = mem_addr(w, ptr_inc(head_q[w]));
		end else begin
			raddr = mem_addr(victim, tail_q[victim]);
		end
		rd_en          = cmd.eval && (do_pop || do_steal);
		stat.need_load = do_pop || do_steal;
	end

	// Task memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= task_time[SW-1:0];
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Pointers and worker timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				rem_q[i]  <= '0;
			end
		end else begin
			if (wr_en) begin
				tail_q[sel_q] <= tail_next;
			end
			if (cmd.eval) begin
				if (busy) begin
					rem_q[w] <= rem_q[w] - 1'b1;
				end else if (do_pop) begin
					head_q[w] <= ptr_inc(head_q[w]);
				end else if (do_steal) begin
					tail_q[victim] <= ptr_dec(tail_q[victim]);
				end
			end
			if (cmd.load) begin
				rem_q[w] <= rdata_q;
			end
		end
	end

	// Per-tick assignment and steal record
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			assigned_q <= (has_task && !sel_full) ? sel_q : Q_NONE;
			overflow_q <= has_task && sel_full;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				steal_q[i] <= STEAL_NONE;
			end
		end else if (cmd.eval && do_steal) begin
			steal_q[w] <= steal_code(victim);
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			assigned_queue <= assigned_q;
			overflow       <= overflow_q;
			remaining_a    <= TIME_W'(rem_q[0]);
			remaining_b    <= TIME_W'(rem_q[1]);
			remaining_c    <= TIME_W'(rem_q[2]);
			steal_src_a    <= steal_q[0];
			steal_src_b    <= steal_q[1];
			steal_src_c    <= steal_q[2];
			count_a        <= CNT_W'(cnt[0]);
			count_b        <= CNT_W'(cnt[1]);
			count_c        <= CNT_W'(cnt[2]);
		end
	end

endmodule

### src/three_queue_work_stealing_scheduler.sv
// ----------------------------------------------------------------------------
// three_queue_work_stealing_scheduler
// Three-deque task scheduler with per-worker timers and work stealing.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction (in_valid/in_ready) is one scheduler tick. When
//   has_task is set, task_time is appended to the emptiest deque (ties A, B,
//   C); a full deque drops the task and flags overflow. Workers A, B and C
//   then run in order: count down, pop their own front, or steal the rear
//   of the fuller other deque.
//   One result transaction (out_valid/out_ready) follows every tick.
// Timing:
//   The accept cycle performs the arrival. Each worker phase then has an
//   evaluate state, followed by a load state when it pops or steals, since
//   the task memory read is registered. A done state then hands the result
//   to the output register, and the controller returns to idle, where the
//   next tick is taken.
// Reset and stall:
//   arst_n empties all deques and idles all workers; no clearing pass runs.
//   A stalled receiver holds the result; the next tick is still accepted
//   and runs to completion, then waits until the held result is taken.
// ----------------------------------------------------------------------------
module three_queue_work_stealing_scheduler
	import tqws_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              has_task,
	input  logic [TIME_W-1:0] task_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QSEL_W-1:0] assigned_queue,
	output logic              overflow,
	output logic [TIME_W-1:0] remaining_a,
	output logic [TIME_W-1:0] remaining_b,
	output logic [TIME_W-1:0] remaining_c,
	output logic [QSEL_W-1:0] steal_src_a,
	output logic [QSEL_W-1:0] steal_src_b,
	output logic [QSEL_W-1:0] steal_src_c,
	output logic [CNT_W-1:0]  count_a,
	output logic [CNT_W-1:0]  count_b,
	output logic [CNT_W-1:0]  count_c
);

	tqws_cmd_t  cmd;
	tqws_stat_t stat;

	// Tick sequencer
	tqws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Deques, timers and result registers
	tqws_dpath #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.TIME_BITS   (TIME_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.has_task       (has_task),
		.task_time      (task_time),
		.assigned_queue (assigned_queue),
		.overflow       (overflow),
		.remaining_a    (remaining_a),
		.remaining_b    (remaining_b),
		.remaining_c    (remaining_c),
		.steal_src_a    (steal_src_a),
		.steal_src_b    (steal_src_b),
		.steal_src_c    (steal_src_c),
		.count_a        (count_a),
		.count_b        (count_b),
		.count_c        (count_c)
	);

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: three-queue work-stealing scheduler testbench
// Drives scheduler ticks over valid/ready and checks every result transaction
// against a cycle-free model of the three deques and the three workers.
// A short directed table comes first, then phased random load.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tqws_pkg::*;

	localparam int RANDOM_TICKS = 900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;

	localparam logic [QSEL_W-1:0] QUEUE_CODE [NUM_QUEUES] = '{Q_A, Q_B, Q_C};
	localparam logic [QSEL_W-1:0] STEAL_CODE [NUM_QUEUES] = '{STEAL_A, STEAL_B, STEAL_C};

	typedef struct packed {
		logic [QSEL_W-1:0] queue;
		logic              ovf;
		logic [TIME_W-1:0] rem_a;
		logic [TIME_W-1:0] rem_b;
		logic [TIME_W-1:0] rem_c;
		logic [QSEL_W-1:0] src_a;
		logic [QSEL_W-1:0] src_b;
		logic [QSEL_W-1:0] src_c;
		logic [CNT_W-1:0]  cnt_a;
		logic [CNT_W-1:0]  cnt_b;
		logic [CNT_W-1:0]  cnt_c;
	} tick_result_t;

	typedef struct packed {
		logic              has;
		logic [TIME_W-1:0] len;
		logic              typed;
		tick_result_t      res;
	} stim_row_t;

	typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} load_phase_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              has_task  = 1'b0;
	logic [TIME_W-1:0] task_time = '0;
	logic              out_ready = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [QSEL_W-1:0] assigned_queue;
	logic              overflow;
	logic [TIME_W-1:0] remaining_a, remaining_b, remaining_c;
	logic [QSEL_W-1:0] steal_src_a, steal_src_b, steal_src_c;
	logic [CNT_W-1:0]  count_a, count_b, count_c;

	// Scheduler model state
	logic [TIME_W-1:0] dq_store [NUM_QUEUES][QUEUE_SLOTS_DEF];
	logic [CNT_W-1:0]  dq_head [NUM_QUEUES];
	logic [CNT_W-1:0]  dq_tail [NUM_QUEUES];
	logic [TIME_W-1:0] worker_left [NUM_QUEUES];

	tick_result_t expected_results [$];
	stim_row_t    directed_rows [$];
	int           error_count = 0;
	int           cycle_count = 0;
	int unsigned  burst_left = 0;
	rx_mode_t     rx_mode = RX_OPEN;
	int unsigned  rx_left = 0;

	three_queue_work_stealing_scheduler i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.has_task      (has_task),
		.task_time     (task_time),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.assigned_queue(assigned_queue),
		.overflow      (overflow),
		.remaining_a   (remaining_a),
		.remaining_b   (remaining_b),
		.remaining_c   (remaining_c),
		.steal_src_a   (steal_src_a),
		.steal_src_b   (steal_src_b),
		.steal_src_c   (steal_src_c),
		.count_a       (count_a),
		.count_b       (count_b),
		.count_c       (count_c)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Tasks waiting in one deque; the pointers wrap at 16 slots
	function automatic logic [CNT_W-1:0] dq_depth(input int q);
		return dq_tail[q] - dq_head[q];
	endfunction

	// Advance the model by one tick and return the result it produces
	function automatic tick_result_t schedule_tick(input logic has, input logic [TIME_W-1:0] len);
		tick_result_t r;
		logic [QSEL_W-1:0] src [NUM_QUEUES];
		int q, o1, o2, v;
		r = '0;
		r.queue = Q_NONE;
		for (int w = 0; w < NUM_QUEUES; w++)
			src[w] = STEAL_NONE;
		// Append to the emptiest deque, ties to the earlier one; drop when full
		if (has) begin
			if (dq_depth(0) <= dq_depth(1) && dq_depth(0) <= dq_depth(2))
				q = 0;
			else if (dq_depth(1) <= dq_depth(2))
				q = 1;
			else
				q = 2;
			if (dq_depth(q) == CNT_W'(QUEUE_SLOTS_DEF - 1)) begin
				r.ovf = 1'b1;
			end else begin
				dq_tail[q] = dq_tail[q] + 1'b1;
				dq_store[q][dq_tail[q]] = len;
				r.queue = QUEUE_CODE[q];
			end
		end
		// Workers in order: count down, pop own front, or steal a rear
		for (int w = 0; w < NUM_QUEUES; w++) begin
			if (worker_left[w] != 0) begin
				worker_left[w] = worker_left[w] - 1'b1;
			end else if (dq_depth(w) != 0) begin
				dq_head[w] = dq_head[w] + 1'b1;
				worker_left[w] = dq_store[w][dq_head[w]];
			end else begin
				o1 = (w == 0) ? 1 : 0;
				o2 = (w == 2) ? 1 : 2;
				v = (dq_depth(o1) >= dq_depth(o2)) ? o1 : o2;
				if (dq_depth(v) != 0) begin
					worker_left[w] = dq_store[v][dq_tail[v]];
					dq_tail[v] = dq_tail[v] - 1'b1;
					src[w] = STEAL_CODE[v];
				end
			end
		end
		r.rem_a = worker_left[0];
		r.rem_b = worker_left[1];
		r.rem_c = worker_left[2];
		r.src_a = src[0];
		r.src_b = src[1];
		r.src_c = src[2];
		r.cnt_a = dq_depth(0);
		r.cnt_b = dq_depth(1);
		r.cnt_c = dq_depth(2);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [3:0] exp, input logic [3:0] act);
		if (exp !== act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			error_count++;
		end
	endtask

	// Present one tick, hold it until the transaction completes, then predict
	task automatic send_tick(input logic has, input logic [TIME_W-1:0] len,
			input logic typed, input tick_result_t typed_res);
		tick_result_t predicted;
		in_valid  <= 1'b1;
		has_task  <= has;
		task_time <= len;
		do @(posedge clk); while (!in_ready);
		predicted = schedule_tick(has, len);
		expected_results.push_back(typed ? typed_res : predicted);
	endtask

	// Work in bursts; between bursts idle, and on request wait for all results
	task automatic pace_sender(input logic drain);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		if (drain && gap == 0)
			gap = 1;
		if (gap != 0) begin
			in_valid <= 1'b0;
			while (drain && expected_results.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver stalls on its own pattern of open, random, sparse and held stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= (rx_left % 24 == 0);
		endcase
	end

	// Compare each result transaction with the oldest expected tick result
	always @(posedge clk) begin
		tick_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no tick outstanding");
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				check_field("assigned_queue", 4'(exp_res.queue), 4'(assigned_queue));
				check_field("overflow", 4'(exp_res.ovf), 4'(overflow));
				check_field("remaining_a", exp_res.rem_a, remaining_a);
				check_field("remaining_b", exp_res.rem_b, remaining_b);
				check_field("remaining_c", exp_res.rem_c, remaining_c);
				check_field("steal_src_a", 4'(exp_res.src_a), 4'(steal_src_a));
				check_field("steal_src_b", 4'(exp_res.src_b), 4'(steal_src_b));
				check_field("steal_src_c", 4'(exp_res.src_c), 4'(steal_src_c));
				check_field("count_a", exp_res.cnt_a, count_a);
				check_field("count_b", exp_res.cnt_b, count_b);
				check_field("count_c", exp_res.cnt_c, count_c);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		tick_result_t res, zero_res;
		load_phase_t  phase;
		int unsigned  phase_left;
		logic         has, pause;
		logic [TIME_W-1:0] len;

		// Clear the model to its reset state
		for (int q = 0; q < NUM_QUEUES; q++) begin
			dq_head[q] = '0;
			dq_tail[q] = '0;
			worker_left[q] = '0;
			for (int s = 0; s < QUEUE_SLOTS_DEF; s++)
				dq_store[q][s] = '0;
		end

		// Directed table: the first three ticks after reset are typed in
		zero_res = '0;
		res = '0;
		res.queue = Q_NONE;
		directed_rows.push_back('{1'b0, 4'd0, 1'b1, res});
		res.queue = Q_A;
		res.rem_a = 4'd15;
		directed_rows.push_back('{1'b1, 4'd15, 1'b1, res});
		res.queue = Q_NONE;
		res.rem_a = 4'd14;
		directed_rows.push_back('{1'b0, 4'd9, 1'b1, res});
		// Zero-length task, then a mix of extremes to build and steal
		directed_rows.push_back('{1'b1, 4'd0, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd1, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd8, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd5, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd10, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd2, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd4, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd3, 1'b0, zero_res});
		directed_rows.push_back('{1'b0, 4'd15, 1'b0, zero_res});
		directed_rows.push_back('{1'b0, 4'd0, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd6, 1'b0, zero_res});
		directed_rows.push_back('{1'b0, 4'd0, 1'b0, zero_res});
		directed_rows.push_back('{1'b0, 4'd0, 1'b0, zero_res});
		directed_rows.push_back('{1'b1, 4'd12, 1'b0, zero_res});
		directed_rows.push_back('{1'b0, 4'd0, 1'b0, zero_res});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			pace_sender(1'b0);
			send_tick(directed_rows[i].has, directed_rows[i].len,
				directed_rows[i].typed, directed_rows[i].res);
		end

		// Random load in phases; open with a long fill to reach full deques
		phase = PH_FILL;
		phase_left = 120;
		pause = 1'b1;
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			if (phase_left == 0) begin
				phase = load_phase_t'($urandom_range(0, 2));
				phase_left = $urandom_range(20, 150);
				pause = ($urandom_range(0, 2) == 0);
			end
			phase_left--;
			case (phase)
				PH_FILL: begin
					has = ($urandom_range(0, 19) != 0);
					len = 4'($urandom_range(10, 15));
				end
				PH_MIXED: begin
					has = 1'($urandom_range(0, 1));
					len = ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
				end
				default: begin
					has = ($urandom_range(0, 9) == 0);
					len = 4'($urandom_range(0, 15));
				end
			endcase
			pace_sender(pause);
			pause = 1'b0;
			send_tick(has, len, 1'b0, zero_res);
		end
		in_valid <= 1'b0;

		// Drain, then watch for stray result transactions
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
